// ===== sv/sorted_held_note_table_core_macros.svh =====
// Assertion macros shared by the checker of the sorted held-note table.
`ifndef SORTED_HELD_NOTE_TABLE_CORE_MACROS_SVH
`define SORTED_HELD_NOTE_TABLE_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, switched off during reset.
`define SNT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted held-note table: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, switched off during reset.
`define SNT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted held-note table: next-cycle check failed");

`endif

// ===== sv/snt_pkg.sv =====
// Types, codes and sizes shared by the sorted held-note table modules.
package snt_pkg;

  // Table size and the widths that follow from it.
  localparam int MAX_HELD = 32;
  localparam int CNT_W    = $clog2(MAX_HELD + 1);
  localparam int IDX_W    = $clog2(MAX_HELD);
  localparam int HELD_W   = 6;

  // Operation codes of a command word.
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_DUMP   = 2'd3;

  // Status codes of a result word.
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  // Actions broadcast to every cell of the chain.
  localparam logic [2:0] ACT_HOLD = 3'd0;
  localparam logic [2:0] ACT_FLAG = 3'd1;
  localparam logic [2:0] ACT_INS  = 3'd2;
  localparam logic [2:0] ACT_DEL  = 3'd3;
  localparam logic [2:0] ACT_ROT  = 3'd4;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] note;
    logic [7:0] velocity;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              entry_valid;
    logic [7:0]        out_note;
    logic [7:0]        out_velocity;
    logic [HELD_W-1:0] held_count;
    logic              last;
  } res_t;

  // One stored entry of the table.
  typedef struct packed {
    logic [7:0] note;
    logic [7:0] vel;
  } slot_t;

  // Control broadcast from the sequencer to the cells.
  typedef struct packed {
    logic [2:0] act;
    logic [7:0] key_note;
    logic [7:0] key_vel;
  } cell_ctl_t;

endpackage

// ===== sv/snt_cell.sv =====
// One cell of the sorted chain: holds one entry and moves it to or from its neighbours.
module snt_cell (
  input  logic               clk,
  input  snt_pkg::cell_ctl_t ctl,
  input  logic               occ,
  input  logic               tail,
  input  logic               lt_left,
  input  snt_pkg::slot_t     left,
  input  snt_pkg::slot_t     right,
  input  snt_pkg::slot_t     head,
  output snt_pkg::slot_t     slot,
  output logic               lt,
  output logic               eq
);

  // Compare against the key, then shift right for an insert, left for a delete,
  // or rotate towards the head while the table is dumped.
  always_ff @(posedge clk) begin
    unique case (ctl.act)
      snt_pkg::ACT_FLAG: begin
        lt <= occ && (slot.note < ctl.key_note);
        eq <= occ && (slot.note == ctl.key_note);
      end
      snt_pkg::ACT_INS: begin
        if (!lt) begin
          if (lt_left) begin
            slot.note <= ctl.key_note;
            slot.vel  <= ctl.key_vel;
          end else begin
            slot <= left;
          end
        end
      end
      snt_pkg::ACT_DEL: begin
        if (!lt) begin
          slot <= right;
        end
      end
      snt_pkg::ACT_ROT: begin
        slot <= tail ? head : right;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sv/sorted_held_note_table_core.sv =====
// Add, remove, clear and an empty dump pass through the compare and apply states, write their
// result word once the result register is free, and only then return to idle for the next command.
// A dump of a non-empty table writes its first entry after the compare and apply states, then
// one per cycle as the chain rotates out of the head cell, holding whenever results stall.
// Reset empties the table at once; the entry stores are not cleared and need no pass.
// Top level of the sorted held-note table: sequencer, cell chain and result register.
module sorted_held_note_table_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  snt_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_stall,
  output snt_pkg::res_t res
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CMP   = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;
  localparam logic [1:0] S_DUMP  = 2'd3;

  logic [1:0]                state;
  logic [1:0]                state_next;
  logic [snt_pkg::CNT_W-1:0] count;
  logic [snt_pkg::CNT_W-1:0] count_next;
  logic [snt_pkg::CNT_W-1:0] count_m1;
  logic [snt_pkg::IDX_W-1:0] dump_idx;
  logic [snt_pkg::IDX_W-1:0] dump_idx_next;
  snt_pkg::cmd_t             cmd_q;
  snt_pkg::res_t             res_next;
  snt_pkg::cell_ctl_t        ctl;
  logic                      emit;
  logic                      slot_free;
  logic                      hit;
  logic                      full;
  logic                      dump_last;

  snt_pkg::slot_t            slots  [snt_pkg::MAX_HELD];
  logic [snt_pkg::MAX_HELD-1:0] lt_vec;
  logic [snt_pkg::MAX_HELD-1:0] eq_vec;

  assign cmd_stall = rst || (state != S_IDLE);
  assign slot_free = !res_valid || !res_stall;
  assign hit       = |eq_vec;
  assign full      = (count == snt_pkg::CNT_W'(snt_pkg::MAX_HELD));
  assign count_m1  = count - snt_pkg::CNT_W'(1);
  assign dump_last = (snt_pkg::CNT_W'(dump_idx) == count_m1);

  // The chain of cells; the ends tie off to themselves or to the key.
  for (genvar i = 0; i < snt_pkg::MAX_HELD; i++) begin : g_cell
    snt_pkg::slot_t left_w;
    snt_pkg::slot_t right_w;
    logic           lt_left_w;

    if (i == 0) begin : g_first
      assign left_w    = slots[0];
      assign lt_left_w = 1'b1;
    end else begin : g_inner_l
      assign left_w    = slots[i-1];
      assign lt_left_w = lt_vec[i-1];
    end

    if (i == snt_pkg::MAX_HELD - 1) begin : g_last
      assign right_w = slots[i];
    end else begin : g_inner_r
      assign right_w = slots[i+1];
    end

    snt_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .occ     (snt_pkg::CNT_W'(i) < count),
      .tail    (snt_pkg::CNT_W'(i) == count_m1),
      .lt_left (lt_left_w),
      .left    (left_w),
      .right   (right_w),
      .head    (slots[0]),
      .slot    (slots[i]),
      .lt      (lt_vec[i]),
      .eq      (eq_vec[i])
    );
  end

  // Sequencer: picks the cell action, the next count and the result word.
  always_comb begin
    state_next    = state;
    count_next    = count;
    dump_idx_next = dump_idx;
    emit          = 1'b0;
    ctl.act       = snt_pkg::ACT_HOLD;
    ctl.key_note  = cmd_q.note;
    ctl.key_vel   = cmd_q.velocity;
    res_next.status       = snt_pkg::ST_DONE;
    res_next.entry_valid  = 1'b0;
    res_next.out_note     = 8'd0;
    res_next.out_velocity = 8'd0;
    res_next.last         = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        ctl.act    = snt_pkg::ACT_FLAG;
        state_next = S_APPLY;
      end
      S_APPLY: begin
        if (cmd_q.opcode == snt_pkg::OP_DUMP && count != '0) begin
          dump_idx_next = '0;
          state_next    = S_DUMP;
        end else if (slot_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          unique case (cmd_q.opcode)
            snt_pkg::OP_ADD: begin
              if (hit) begin
                res_next.status = snt_pkg::ST_DUP;
              end else if (full) begin
                res_next.status = snt_pkg::ST_FULL;
              end else begin
                ctl.act    = snt_pkg::ACT_INS;
                count_next = count + snt_pkg::CNT_W'(1);
              end
            end
            snt_pkg::OP_REMOVE: begin
              if (hit) begin
                ctl.act    = snt_pkg::ACT_DEL;
                count_next = count_m1;
              end else begin
                res_next.status = snt_pkg::ST_MISS;
              end
            end
            snt_pkg::OP_CLEAR: begin
              count_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_DUMP: begin
        if (slot_free) begin
          emit                  = 1'b1;
          ctl.act               = snt_pkg::ACT_ROT;
          res_next.entry_valid  = 1'b1;
          res_next.out_note     = slots[0].note;
          res_next.out_velocity = slots[0].vel;
          res_next.last         = dump_last;
          dump_idx_next         = dump_idx + snt_pkg::IDX_W'(1);
          if (dump_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    res_next.held_count = snt_pkg::HELD_W'(count_next);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      res_valid <= emit || (res_valid && res_stall);
    end
  end

  // Payload registers: command word, dump position and result word.
  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      cmd_q <= cmd;
    end
    dump_idx <= dump_idx_next;
    if (emit) begin
      res <= res_next;
    end
  end

endmodule

// ===== sv/snt_checker.sv =====
// Port-level checker for the sorted held-note table, bound to its top level.
`include "sorted_held_note_table_core_macros.svh"

module snt_checker (
  input logic          clk,
  input logic          rst,
  input logic          cmd_valid,
  input logic          cmd_stall,
  input snt_pkg::cmd_t cmd,
  input logic          res_valid,
  input logic          res_stall,
  input snt_pkg::res_t res
);

  // A stalled result word stays put.
  `SNT_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res))

  // The table works on one command at a time, so it stalls right after taking one.
  `SNT_ASSERT_NEXT(a_busy_after_accept, cmd_valid && !cmd_stall, cmd_stall)

  // Dumped entries always report success.
  `SNT_ASSERT_NOW(a_entry_done, res_valid && res.entry_valid, res.status == snt_pkg::ST_DONE)

  // A word without an entry is the only result of its command.
  `SNT_ASSERT_NOW(a_single_last, res_valid && !res.entry_valid, res.last)

endmodule

bind sorted_held_note_table_core snt_checker u_snt_checker (.*);

// ===== test/tb_sorted_held_note_table_core.sv =====
// Testbench for the sorted held-note table: directed and random command words.
`timescale 1ns / 100ps

module tb_sorted_held_note_table_core;
  import snt_pkg::*;

  // Receiver stall behaviour, chosen at random for each stretch.
  typedef enum logic [1:0] {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY
  } rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  // Predicted table contents and the result words still to arrive.
  logic [7:0] held_notes [MAX_HELD];
  logic [7:0] held_vels [MAX_HELD];
  int         held_total = 0;
  res_t       pending_results [$];

  int       error_count = 0;
  int       burst_left = 0;
  rx_mode_t rx_mode = RX_FREE;
  int       rx_left = 0;

  sorted_held_note_table_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one accepted command to the predicted table and queue the words it should produce.
  function automatic void predict_table_op(input cmd_t c);
    res_t r;
    int   pos;
    r = '0;
    r.status = ST_DONE;
    r.last = 1'b1;
    case (c.opcode)
      OP_ADD: begin
        pos = 0;
        while (pos < held_total && held_notes[pos] < c.note) pos++;
        if (pos < held_total && held_notes[pos] == c.note) begin
          r.status = ST_DUP;
        end else if (held_total >= MAX_HELD) begin
          r.status = ST_FULL;
        end else begin
          for (int i = held_total; i > pos; i--) begin
            held_notes[i] = held_notes[i-1];
            held_vels[i] = held_vels[i-1];
          end
          held_notes[pos] = c.note;
          held_vels[pos] = c.velocity;
          held_total++;
        end
      end
      OP_REMOVE: begin
        pos = 0;
        while (pos < held_total && held_notes[pos] != c.note) pos++;
        if (pos >= held_total) begin
          r.status = ST_MISS;
        end else begin
          for (int i = pos; i + 1 < held_total; i++) begin
            held_notes[i] = held_notes[i+1];
            held_vels[i] = held_vels[i+1];
          end
          held_total--;
        end
      end
      OP_CLEAR: begin
        held_total = 0;
      end
      default: begin
        // A dump of a non-empty table gives one word per held note.
        if (held_total > 0) begin
          for (int k = 0; k < held_total; k++) begin
            r.entry_valid = 1'b1;
            r.out_note = held_notes[k];
            r.out_velocity = held_vels[k];
            r.held_count = HELD_W'(held_total);
            r.last = (k == held_total - 1);
            pending_results.push_back(r);
          end
          return;
        end
      end
    endcase
    r.held_count = HELD_W'(held_total);
    pending_results.push_back(r);
  endfunction

  // Send one command word in bursts with random gaps, then predict it once accepted.
  task automatic issue_command(input logic [1:0] op, input logic [7:0] nt,
                               input logic [7:0] vel);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        cmd_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    cmd_valid <= 1'b1;
    cmd <= '{opcode: op, note: nt, velocity: vel};
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    predict_table_op('{opcode: op, note: nt, velocity: vel});
  endtask

  // Hold off the sender until every expected word has come back.
  task automatic wait_drain();
    cmd_valid <= 1'b0;
    burst_left = 0;
    wait (pending_results.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  // Receiver stall pattern: free, lightly stalled or heavily stalled stretches.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_left = $urandom_range(8, 64);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_FREE:  res_stall <= 1'b0;
      RX_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
      default:  res_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with no expectation waiting: %h", res);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (res.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res.status);
          error_count++;
        end
        if (res.entry_valid !== want.entry_valid) begin
          $error("entry_valid: expected %0d, got %0d", want.entry_valid, res.entry_valid);
          error_count++;
        end
        if (res.out_note !== want.out_note) begin
          $error("out_note: expected %0d, got %0d", want.out_note, res.out_note);
          error_count++;
        end
        if (res.out_velocity !== want.out_velocity) begin
          $error("out_velocity: expected %0d, got %0d", want.out_velocity, res.out_velocity);
          error_count++;
        end
        if (res.held_count !== want.held_count) begin
          $error("held_count: expected %0d, got %0d", want.held_count, res.held_count);
          error_count++;
        end
        if (res.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, res.last);
          error_count++;
        end
      end
    end
  end

  // Operations on an empty table: dump, missing remove and clear.
  task automatic test_empty_table();
    issue_command(OP_DUMP, 8'd0, 8'd0);
    issue_command(OP_REMOVE, 8'd7, 8'd0);
    issue_command(OP_CLEAR, 8'hFF, 8'hFF);
    wait_drain();
  endtask

  // Extremes of note and velocity, duplicates, misses and ordering.
  task automatic test_basic_ops();
    issue_command(OP_ADD, 8'd0, 8'd255);
    issue_command(OP_ADD, 8'd255, 8'd0);
    issue_command(OP_ADD, 8'd128, 8'h5A);
    issue_command(OP_ADD, 8'd128, 8'hA5);
    issue_command(OP_ADD, 8'd1, 8'h01);
    issue_command(OP_ADD, 8'd254, 8'hFE);
    issue_command(OP_DUMP, 8'hAA, 8'h55);
    issue_command(OP_REMOVE, 8'd128, 8'd0);
    issue_command(OP_REMOVE, 8'd128, 8'd0);
    issue_command(OP_REMOVE, 8'd0, 8'd0);
    issue_command(OP_REMOVE, 8'd255, 8'd0);
    issue_command(OP_DUMP, 8'd0, 8'd0);
    issue_command(OP_CLEAR, 8'd0, 8'd0);
    issue_command(OP_DUMP, 8'd0, 8'd0);
    wait_drain();
  endtask

  // Fill the table in scattered order, then overflow, duplicate on full and a full dump.
  task automatic test_full_table();
    logic [7:0] nt;
    for (int k = 0; k < MAX_HELD; k++) begin
      nt = 8'(((k * 13) % MAX_HELD) * 8 + $urandom_range(0, 6));
      issue_command(OP_ADD, nt, 8'($urandom_range(0, 255)));
    end
    // Notes seven above a multiple of eight were never added above, so these are new to the table.
    issue_command(OP_ADD, 8'(8 * $urandom_range(0, 31) + 7), 8'($urandom_range(0, 255)));
    issue_command(OP_ADD, held_notes[$urandom_range(0, MAX_HELD - 1)], 8'hFF);
    issue_command(OP_DUMP, 8'd0, 8'd0);
    issue_command(OP_REMOVE, held_notes[0], 8'd0);
    issue_command(OP_ADD, 8'(8 * $urandom_range(0, 31) + 7), 8'($urandom_range(0, 255)));
    issue_command(OP_DUMP, 8'd0, 8'd0);
    issue_command(OP_CLEAR, 8'd0, 8'd0);
    wait_drain();
  endtask

  // Random operations in segments, each leaning towards filling or emptying the table.
  task automatic test_random_ops();
    int         add_weight;
    int         pick;
    logic [7:0] nt;
    logic [7:0] note_pool [40];
    for (int seg = 0; seg < 4; seg++) begin
      add_weight = $urandom_range(30, 90);
      foreach (note_pool[i]) note_pool[i] = 8'($urandom_range(0, 255));
      for (int n = 0; n < 40; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          issue_command(OP_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end else if (pick < 13) begin
          issue_command(OP_DUMP, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end else if ($urandom_range(0, 99) < add_weight) begin
          nt = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                           : note_pool[$urandom_range(0, 39)];
          issue_command(OP_ADD, nt, 8'($urandom_range(0, 255)));
        end else begin
          if (held_total > 0 && $urandom_range(0, 3) != 0) begin
            nt = held_notes[$urandom_range(0, held_total - 1)];
          end else begin
            nt = 8'($urandom_range(0, 255));
          end
          issue_command(OP_REMOVE, nt, 8'($urandom_range(0, 255)));
        end
      end
      if (seg == 1) begin
        wait_drain();
      end
    end
    wait_drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_basic_ops();
    test_full_table();
    test_random_ops();
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Safety limit, far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
